/* sv/ssnf_pkg.sv */
package ssnf_pkg;

   localparam int MODULE_COUNT_DEFAULT = 2;
   localparam int DIGITS_PER_MODULE    = 4;
   localparam int FRAME_BYTES          = 8;
   localparam int MAG_BITS             = 14;   // 9999 fits in 14 bits
   localparam int BCD_BITS             = 4 * DIGITS_PER_MODULE;
   localparam int CNT_BITS             = $clog2(MAG_BITS);

   localparam logic [7:0] SEG_MINUS     = 8'hBF;
   localparam logic [7:0] SEG_POINT_CLR = 8'h7F;
   localparam logic [7:0] SEG_OFF       = 8'hFF;

   typedef enum logic [1:0] {
      KIND_NUMBER = 2'd0,
      KIND_RAW    = 2'd1,
      KIND_BLANK  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_WRITE,
      ST_FINISH
   } state_type;

   function automatic logic [7:0] glyph(input logic [3:0] code);
      logic [7:0] g;
      unique case (code)
         4'h0: g = 8'hC0;
         4'h1: g = 8'hF9;
         4'h2: g = 8'hA4;
         4'h3: g = 8'hB0;
         4'h4: g = 8'h99;
         4'h5: g = 8'h92;
         4'h6: g = 8'h82;
         4'h7: g = 8'hF8;
         4'h8: g = 8'h80;
         4'h9: g = 8'h90;
         4'hA: g = 8'h88;
         4'hB: g = 8'h83;
         4'hC: g = 8'hC6;
         4'hD: g = 8'hA1;
         4'hE: g = 8'h86;
         4'hF: g = 8'h8E;
      endcase
      return g;
   endfunction

endpackage

/* sv/seven_segment_number_formatter.sv */
// Channel | Direction | Ports                                          | Handshake
// req     | in        | kind number module_select point_position       | req_valid/req_ready
//         |           | prefix_glyph raw_frame                         |
// rsp     | out       | frame                                          | rsp_valid/rsp_ready
//
// A number beat runs the bit-serial binary-to-BCD shifter over all 14
// magnitude bits (one magnitude bit per cycle), then writes the glyphs,
// then loads the output register. Raw, blank and unused kinds go from
// accept straight to the output register load. req_ready returns the
// cycle after the load. One beat is in work at a time.
// Reset (synchronous, active high) sets every store byte to 0xFF (all off)
// and empties the output register.
// A stalled result holds in the output register; a new beat is still taken
// meanwhile and waits in its last step until the register frees up.
module seven_segment_number_formatter
   import ssnf_pkg::*;
#(
   parameter int MODULE_COUNT = MODULE_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic signed [15:0] req_number,
   input  logic        req_module_select,
   input  logic [2:0]  req_point_position,
   input  logic [3:0]  req_prefix_glyph,
   input  logic [63:0] req_raw_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_frame
);

   localparam int STORE_BYTES = MODULE_COUNT * DIGITS_PER_MODULE;

   state_type state_ff, state_in;

   logic [7:0] store_ff [STORE_BYTES];

   logic [1:0]          kind_ff;
   logic                mod_ff;
   logic [2:0]          dp_ff;
   logic [3:0]          pre_ff;
   logic                neg_ff, neg_in;
   logic [MAG_BITS-1:0] mag_ff, mag_in;
   logic [BCD_BITS-1:0] bcd_ff, bcd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_frame_ff, rsp_frame_in;

   logic                accept;
   logic                out_free;
   logic                load_out;
   logic                mod_ok;
   logic signed [15:0]  sat;
   logic signed [15:0]  mag_full;
   logic [BCD_BITS-1:0] bcd_adj;
   logic [2:0]          num_digits;
   logic [7:0]          slot_byte [DIGITS_PER_MODULE];
   logic [63:0]         frame_pack;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign mod_ok    = (int'(req_module_select) < MODULE_COUNT);

   // saturate to what four slots can show, then take the magnitude
   always_comb begin
      if (req_prefix_glyph != 4'd0) begin
         if (req_number > 16'sd999)       sat = 16'sd999;
         else if (req_number < -16'sd99)  sat = -16'sd99;
         else                             sat = req_number;
      end else begin
         if (req_number > 16'sd9999)      sat = 16'sd9999;
         else if (req_number < -16'sd999) sat = -16'sd999;
         else                             sat = req_number;
      end
      neg_in   = sat[15];
      mag_full = sat[15] ? -sat : sat;
   end

   // double dabble: correct each BCD digit, then shift in the next bit
   always_comb begin
      for (int d = 0; d < DIGITS_PER_MODULE; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                        : bcd_ff[4*d +: 4];
      end
   end

   // glyphs of the selected module, lowest slot first
   always_comb begin
      logic [2:0] idx;
      logic       pre_nz;
      pre_nz = (pre_ff != 4'd0);
      priority if (bcd_ff[15:12] != 4'd0) num_digits = 3'd4;
      else if (bcd_ff[11:8] != 4'd0)      num_digits = 3'd3;
      else if (bcd_ff[7:4] != 4'd0)       num_digits = 3'd2;
      else                                num_digits = 3'd1;   // zero shows one '0'
      for (int j = 0; j < DIGITS_PER_MODULE; j++) begin
         idx = 3'(j) - {2'b00, pre_nz};
         if (pre_nz && j == 0) begin
            slot_byte[j] = glyph(pre_ff);
         end else if (idx < num_digits) begin
            slot_byte[j] = glyph(bcd_ff[4*idx[1:0] +: 4]);
         end else if (idx == num_digits && neg_ff) begin
            slot_byte[j] = SEG_MINUS;
         end else begin
            slot_byte[j] = SEG_OFF;
         end
         if (dp_ff == 3'(j + 1)) begin
            slot_byte[j] = slot_byte[j] & SEG_POINT_CLR;
         end
      end
   end

   // bytes past the store read as off, and a blank beat reads all off
   always_comb begin
      for (int k = 0; k < FRAME_BYTES; k++) begin
         if (k < STORE_BYTES) rsp_frame_in[8*k +: 8] = store_ff[k];
         else                 rsp_frame_in[8*k +: 8] = SEG_OFF;
      end
      frame_pack = rsp_frame_in;
      if (kind_ff == KIND_BLANK) rsp_frame_in = '1;
      else                       rsp_frame_in = frame_pack;
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mag_in = mag_full[MAG_BITS-1:0];
               bcd_in = '0;
               cnt_in = CNT_BITS'(MAG_BITS - 1);
               if (req_kind == KIND_NUMBER && mod_ok) state_in = ST_CONV;
               else                                   state_in = ST_FINISH;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_BITS-2:0], mag_ff[MAG_BITS-1]};
            mag_in = {mag_ff[MAG_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      if (accept) begin
         kind_ff <= req_kind;
         mod_ff  <= req_module_select;
         dp_ff   <= req_point_position;
         pre_ff  <= req_prefix_glyph;
         neg_ff  <= neg_in;
      end
      if (load_out) rsp_frame_ff <= rsp_frame_in;
   end

   // segment store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STORE_BYTES; k++) store_ff[k] <= SEG_OFF;
      end else if (accept && req_kind == KIND_RAW) begin
         for (int k = 0; k < STORE_BYTES; k++) begin
            if (k < FRAME_BYTES) store_ff[k] <= req_raw_frame[8*(k % FRAME_BYTES) +: 8];
         end
      end else if (state_ff == ST_WRITE) begin
         for (int k = 0; k < STORE_BYTES; k++) begin
            if (int'(mod_ff) == k / DIGITS_PER_MODULE) begin
               store_ff[k] <= slot_byte[k % DIGITS_PER_MODULE];
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame = rsp_frame_ff;

   // shifter ends after its last bit
   a_conv_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && cnt_ff == '0) |=> (state_ff == ST_WRITE))
      else $error("converter did not hand over to glyph write");

   // converted digits are decimal
   a_bcd_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (bcd_ff[3:0] <= 4'd9 && bcd_ff[7:4] <= 4'd9 &&
                                  bcd_ff[11:8] <= 4'd9 && bcd_ff[15:12] <= 4'd9))
      else $error("BCD digit out of range");

   // blank beat sends all off
   a_blank: assert property (@(posedge clock) disable iff (reset)
      (load_out && kind_ff == KIND_BLANK) |=> (rsp_frame_ff == '1))
      else $error("blank frame not all off");

   // one beat in work at a time
   a_one_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second beat taken while busy");

endmodule
